FILE: src/grid_jump_point_search_assert.svh
// Assertion macros for the grid jump point search RTL.
// Depends on nothing; included inside module bodies.
`ifndef GRID_JUMP_POINT_SEARCH_ASSERT_SVH
`define GRID_JUMP_POINT_SEARCH_ASSERT_SVH
// Implication checked every clock, ignored while reset is high.
`define GJPS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define GJPS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/gjps_pkg.sv
// Shared types and constants for the grid jump point search block.
// Depends on nothing.
package gjps_pkg;
  localparam int GridWidthDef  = 256;
  localparam int GridHeightDef = 256;
  localparam int StepW         = 9;
  localparam logic [StepW-1:0] StepLimitRst = 9'd256;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Direction codes; north is decreasing row, east increasing column.
  localparam logic [2:0] DIR_N  = 3'd0;
  localparam logic [2:0] DIR_S  = 3'd1;
  localparam logic [2:0] DIR_E  = 3'd2;
  localparam logic [2:0] DIR_W  = 3'd3;
  localparam logic [2:0] DIR_NE = 3'd4;
  localparam logic [2:0] DIR_SE = 3'd5;
  localparam logic [2:0] DIR_NW = 3'd6;
  localparam logic [2:0] DIR_SW = 3'd7;

  // Sequencer states. A step probe is issued in a cycle with rvalid low and its
  // data is seen in the following cycle.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_WSTEP,   // straight walk: probe next cell
    S_WSIDE,   // straight walk: probe four side cells
    S_DSTEP,   // diagonal walk: probe next cell
    S_DSIDE,   // diagonal walk: probe four side cells
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [13:0] x;
    logic signed [13:0] y;
  } coord_t;

  function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
    case (d) inside
      DIR_E, DIR_NE, DIR_SE: dir_dx = 2'sd1;
      DIR_W, DIR_NW, DIR_SW: dir_dx = -2'sd1;
      default:               dir_dx = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
    case (d) inside
      DIR_N, DIR_NE, DIR_NW: dir_dy = -2'sd1;
      DIR_S, DIR_SE, DIR_SW: dir_dy = 2'sd1;
      default:               dir_dy = 2'sd0;
    endcase
  endfunction
endpackage

FILE: src/gjps_map.sv
// Occupancy bitmap: one bit per cell, one write and one read port, read
// data registered. Depends on gjps_pkg.
module gjps_map #(
  parameter int GRID_WIDTH  = gjps_pkg::GridWidthDef,
  parameter int GRID_HEIGHT = gjps_pkg::GridHeightDef,
  localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);
  import gjps_pkg::*;
  logic mem [GRID_WIDTH*GRID_HEIGHT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/gjps_walk.sv
// Walk sequencer: straight and diagonal scans by single-cell reads of the
// bitmap. Depends on gjps_pkg and the assertion header.
module gjps_walk #(
  parameter int GRID_WIDTH  = gjps_pkg::GridWidthDef,
  parameter int GRID_HEIGHT = gjps_pkg::GridHeightDef,
  localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      operation,
  input  logic [7:0]                cell_x,
  input  logic [7:0]                cell_y,
  input  logic                      passable,
  input  logic [2:0]                direction,
  input  logic [7:0]                goal_x,
  input  logic [7:0]                goal_y,
  input  logic [gjps_pkg::StepW-1:0] step_limit,
  output logic                      busy,
  output logic                      done,
  output logic                      found,
  output logic [7:0]                jump_x,
  output logic [7:0]                jump_y,
  output logic                      we,
  output logic [AW-1:0]             waddr,
  output logic                      wdata,
  output logic [AW-1:0]             raddr,
  input  logic                      rdata
);
  import gjps_pkg::*;
  `include "grid_jump_point_search_assert.svh"

  localparam int NCELL = GRID_WIDTH * GRID_HEIGHT;

  state_t state, state_next;

  // Query context.
  logic signed [1:0]  ddx, ddy;          // outer direction
  coord_t             gpos;
  // Outer diagonal position and step count.
  coord_t             dpos;
  logic [StepW:0]     dstep;
  // Active straight scan.
  coord_t             spos;
  logic signed [1:0]  sdx, sdy;
  logic [StepW:0]     sstep;
  logic               nested;   // straight scan runs inside the diagonal walk
  logic               phase;    // 0 vertical component, 1 horizontal
  logic [2:0]         probe;    // side probes issued so far
  logic [2:0]         side;     // captured side cell bits
  logic               rvalid;   // a probe was issued last cycle
  logic [AW-1:0]      clr;
  logic               res_found;
  coord_t             res;

  // Next cells of both walks and the decisions shared by the two blocks.
  coord_t s_nxt, d_nxt;
  logic   lim_s, lim_d, s_goal, d_goal, forced;

  // Address of a coordinate, with an out-of-grid flag.
  function automatic logic in_grid(input coord_t c);
    in_grid = (c.x >= 0) && (c.y >= 0) && (c.x < GRID_WIDTH) && (c.y < GRID_HEIGHT);
  endfunction
  function automatic logic [AW-1:0] addr_of(input coord_t c);
    logic [31:0] a;
    a = 32'(c.y) * 32'(GRID_WIDTH) + 32'(c.x);
    addr_of = a[AW-1:0];
  endfunction

  // Probe coordinate and in-grid flag.
  coord_t pc;
  logic   pc_in;
  logic   pc_in_q;
  logic   cell_ok;   // probed cell open
  assign cell_ok = rdata && pc_in_q;

  always_comb begin
    s_nxt.x = spos.x + sdx;
    s_nxt.y = spos.y + sdy;
    d_nxt.x = dpos.x + ddx;
    d_nxt.y = dpos.y + ddy;
  end

  assign lim_s  = (sstep >= {1'b0, step_limit});
  assign lim_d  = (dstep >= {1'b0, step_limit});
  assign s_goal = (s_nxt == gpos);
  assign d_goal = (d_nxt == gpos);
  assign forced = (!side[0] && side[1]) || (!side[2] && cell_ok);

  // Side probe coordinates for the current cell.
  coord_t cur;
  logic signed [1:0] px, py;
  assign cur = (state == S_DSIDE || state == S_DSTEP) ? dpos : spos;
  always_comb begin
    pc = cur;
    px = 2'sd0; py = 2'sd0;
    if (state == S_WSIDE) begin
      // perpendicular offset (sx, sy)
      px = (sdx == 0) ? 2'sd1 : 2'sd0;
      py = (sdx == 0) ? 2'sd0 : 2'sd1;
      unique case (probe[1:0])
        2'd0: begin pc.x = spos.x - px; pc.y = spos.y - py; end
        2'd1: begin pc.x = spos.x - px + sdx; pc.y = spos.y - py + sdy; end
        2'd2: begin pc.x = spos.x + px; pc.y = spos.y + py; end
        default: begin pc.x = spos.x + px + sdx; pc.y = spos.y + py + sdy; end
      endcase
    end else if (state == S_DSIDE) begin
      unique case (probe[1:0])
        2'd0: begin pc.x = dpos.x; pc.y = dpos.y - ddy; end
        2'd1: begin pc.x = dpos.x + ddx; pc.y = dpos.y - ddy; end
        2'd2: begin pc.x = dpos.x - ddx; pc.y = dpos.y; end
        default: begin pc.x = dpos.x - ddx; pc.y = dpos.y + ddy; end
      endcase
    end else if (state == S_WSTEP) begin
      pc = s_nxt;
    end else if (state == S_DSTEP) begin
      pc = d_nxt;
    end
    pc_in = in_grid(pc);
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr;
    wdata = 1'b0;
    if (state == S_CLEAR) begin
      we = 1'b1;
    end else if (state == S_IDLE && start && operation == OP_WRITE &&
                 32'(cell_x) < 32'(GRID_WIDTH) && 32'(cell_y) < 32'(GRID_HEIGHT)) begin
      we    = 1'b1;
      waddr = AW'(32'(cell_y) * 32'(GRID_WIDTH) + 32'(cell_x));
      wdata = passable;
    end
    raddr = pc_in ? addr_of(pc) : '0;
  end

  assign busy = (state != S_IDLE);

  // Next state. Side probes finish when the fourth word is back (probe 4).
  always_comb begin
    state_next = state;
    unique case (state) inside
      S_CLEAR: begin
        if (clr == AW'(NCELL - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (operation == OP_WRITE) state_next = S_DONE;
          else state_next = direction[2] ? S_DSTEP : S_WSTEP;
        end
      end
      S_WSTEP: begin
        if (!rvalid) begin
          if (lim_s) begin
            if (!nested || sstep != '0) state_next = S_DONE;
            else if (phase) state_next = S_DSTEP;
          end
        end else if (!cell_ok) begin
          if (!nested) state_next = S_DONE;
          else if (phase) state_next = S_DSTEP;
        end else if (s_goal) begin
          state_next = S_DONE;
        end else begin
          state_next = S_WSIDE;
        end
      end
      S_WSIDE, S_DSIDE: begin
        if (rvalid && probe == 3'd4) state_next = forced ? S_DONE : S_WSTEP;
      end
      S_DSTEP: begin
        if (!rvalid) begin
          if (lim_d) state_next = S_DONE;
        end else if (!cell_ok || d_goal) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DSIDE;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    pc_in_q <= pc_in;
    if (rst) begin
      state  <= S_CLEAR;
      clr    <= '0;
      rvalid <= 1'b0;
      done   <= 1'b0;
      found  <= 1'b0;
      jump_x <= '0;
      jump_y <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state) inside
        S_CLEAR: begin
          clr <= clr + 1'b1;
        end
        S_IDLE: begin
          rvalid <= 1'b0;
          if (start) begin
            res_found <= 1'b0;
            res <= '0;
            if (operation == OP_QUERY) begin
              ddx <= dir_dx(direction); ddy <= dir_dy(direction);
              gpos.x <= 14'(goal_x); gpos.y <= 14'(goal_y);
              dpos.x <= 14'(cell_x); dpos.y <= 14'(cell_y);
              spos.x <= 14'(cell_x); spos.y <= 14'(cell_y);
              sdx <= dir_dx(direction); sdy <= dir_dy(direction);
              dstep <= '0; sstep <= '0;
              nested <= 1'b0;
            end
          end
        end
        S_WSTEP: begin
          if (!rvalid) begin
            if (lim_s) begin
              // limit spent: straight walk ends on the last cell reached
              if (!nested) begin
                res_found <= (sstep != '0); res <= spos;
              end else if (sstep == '0 && !phase) begin
                phase <= 1'b1; spos <= dpos; sdx <= ddx; sdy <= 2'sd0;
              end
            end else begin
              rvalid <= 1'b1;
            end
          end else begin
            rvalid <= 1'b0;
            if (!cell_ok) begin
              if (nested) begin
                if (!phase) begin
                  phase <= 1'b1; spos <= dpos; sdx <= ddx; sdy <= 2'sd0; sstep <= '0;
                end
              end else begin
                res_found <= 1'b0; res <= '0;
              end
            end else begin
              spos <= s_nxt;
              sstep <= sstep + 1'b1;
              if (!nested) begin res_found <= 1'b1; res <= s_nxt; end
              probe <= '0;
            end
          end
        end
        S_WSIDE, S_DSIDE: begin
          if (!rvalid) begin
            rvalid <= 1'b1;
            probe <= probe + 1'b1;
          end else if (probe == 3'd4) begin
            rvalid <= 1'b0;
            if (!forced && state == S_DSIDE) begin
              // diagonal: run vertical component scan
              nested <= 1'b1; phase <= 1'b0;
              spos <= dpos; sdx <= 2'sd0; sdy <= ddy; sstep <= '0;
            end
          end else begin
            // data here belongs to the probe issued last cycle
            side[probe[1:0] - 2'd1] <= cell_ok;
            probe <= probe + 1'b1;
          end
        end
        S_DSTEP: begin
          nested <= 1'b0;
          if (!rvalid) begin
            if (!lim_d) rvalid <= 1'b1;
          end else begin
            rvalid <= 1'b0;
            if (!cell_ok) begin
              res_found <= 1'b0; res <= '0;
            end else begin
              dpos <= d_nxt;
              res_found <= 1'b1; res <= d_nxt;
              dstep <= dstep + 1'b1;
              probe <= '0;
            end
          end
        end
        S_DONE: begin
          done   <= 1'b1;
          found  <= res_found;
          jump_x <= res_found ? res.x[7:0] : 8'd0;
          jump_y <= res_found ? res.y[7:0] : 8'd0;
        end
        default: ;
      endcase
    end
  end

  `GJPS_ASSERT_NXT(a_done_pulse, clk, rst, done, !done)
  `GJPS_ASSERT_IMP(a_idle_accept, clk, rst, start && !busy, state == S_IDLE)
  `GJPS_ASSERT_NXT(a_done_after, clk, rst, state == S_DONE, done && state == S_IDLE)
  `GJPS_ASSERT_IMP(a_nofound_zero, clk, rst, done && !found, jump_x == 8'd0 && jump_y == 8'd0)
endmodule

FILE: src/grid_jump_point_search.sv
// Top level of the grid jump point search block.
// Depends on gjps_pkg, gjps_map and gjps_walk.
//
// Usage:
//  - Commands: drive operation and the cell, direction and goal fields and
//    raise start; the word is taken at a clock edge where busy is low.
//  - operation 0 writes one cell of the bitmap; operation 1 runs a query.
//  - Each command gives exactly one result word: done is high for one cycle
//    with found, jump_x and jump_y. The receiver cannot hold it off.
//  - Query reads: a query reads one cell at a time over the single read
//    port of the bitmap. A straight step reads the next cell, then its four
//    side cells; a diagonal step does the same, then runs its nested
//    straight scans (vertical first). The step limit bounds each walk. A
//    write goes straight to S_DONE, which registers its result word.
//  - Throughput: one command at a time; the next is taken in the cycle
//    that done is high.
//  - Configuration: the user must write step_limit over cfg_valid/cfg_ready
//    only while idle; the block itself does not enforce this.
//  - Reset: step_limit returns to 256 and a clearing pass writes every cell
//    blocked, one cell a cycle; busy is high throughout and no command is
//    taken.
module grid_jump_point_search #(
  parameter int GRID_WIDTH  = gjps_pkg::GridWidthDef,
  parameter int GRID_HEIGHT = gjps_pkg::GridHeightDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation,
  input  logic [7:0]                  cell_x,
  input  logic [7:0]                  cell_y,
  input  logic                        passable,
  input  logic [2:0]                  direction,
  input  logic [7:0]                  goal_x,
  input  logic [7:0]                  goal_y,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gjps_pkg::StepW-1:0]  cfg_data,
  output logic                        done,
  output logic                        found,
  output logic [7:0]                  jump_x,
  output logic [7:0]                  jump_y
);
  import gjps_pkg::*;
  localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT);

  logic [StepW-1:0] step_limit;
  logic             we, wdata, rdata;
  logic [AW-1:0]    waddr, raddr;

  // Hold the step limit; always ready.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= StepLimitRst;
    end else if (cfg_valid) begin
      step_limit <= cfg_data;
    end
  end

  gjps_map #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_map (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  gjps_walk #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_walk (
    .clk(clk), .rst(rst), .start(start), .operation(operation),
    .cell_x(cell_x), .cell_y(cell_y), .passable(passable),
    .direction(direction), .goal_x(goal_x), .goal_y(goal_y),
    .step_limit(step_limit), .busy(busy), .done(done), .found(found),
    .jump_x(jump_x), .jump_y(jump_y), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );
endmodule

FILE: verif/tb_grid_jump_point_search.sv
// Self-checking testbench for grid_jump_point_search: cell writes and jump queries.
// Depends on gjps_pkg and the grid_jump_point_search RTL; a built-in jump predictor
// checks every result word.
module tb_grid_jump_point_search;
  timeunit 1ns;
  timeprecision 1ps;
  import gjps_pkg::*;

  typedef struct {
    bit       op;
    bit [7:0] cx;
    bit [7:0] cy;
    bit       pass;
    bit [2:0] dir;
    bit [7:0] gx;
    bit [7:0] gy;
  } cmd_t;

  typedef struct {
    bit       hit;
    bit [7:0] jx;
    bit [7:0] jy;
  } jump_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic operation = 1'b0;
  logic [7:0] cell_x = '0, cell_y = '0, goal_x = '0, goal_y = '0;
  logic passable = 1'b0;
  logic [2:0] direction = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [StepW-1:0] cfg_data = '0;
  logic done, found;
  logic [7:0] jump_x, jump_y;

  grid_jump_point_search dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .cell_x(cell_x), .cell_y(cell_y), .passable(passable), .direction(direction),
    .goal_x(goal_x), .goal_y(goal_y), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .done(done), .found(found), .jump_x(jump_x), .jump_y(jump_y)
  );

  // Predictor state: our own copy of the bitmap and the step limit.
  bit occ_map [65536];
  int unsigned walk_limit = 256;

  cmd_t  cmd_pending [$];
  jump_t jump_expect [$];
  bit    failed = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit open_cell(int x, int y);
    if (x < 0 || y < 0 || x > 255 || y > 255) return 1'b0;
    return occ_map[y * 256 + x];
  endfunction

  // Straight scan; side offsets are perpendicular to the move.
  function automatic bit scan_line(int x, int y, int dx, int dy, int gx, int gy,
                                   output int ox, output int oy);
    int sx, sy;
    bit got;
    sx = (dx == 0) ? 1 : 0;
    sy = (dx == 0) ? 0 : 1;
    got = 1'b0;
    ox = 0;
    oy = 0;
    for (int unsigned s = 1; s <= walk_limit; s++) begin
      x += dx;
      y += dy;
      if (!open_cell(x, y)) return 1'b0;
      got = 1'b1;
      ox = x;
      oy = y;
      if (x == gx && y == gy) break;
      if (!open_cell(x - sx, y - sy) && open_cell(x - sx + dx, y - sy + dy)) break;
      if (!open_cell(x + sx, y + sy) && open_cell(x + sx + dx, y + sy + dy)) break;
    end
    return got;
  endfunction

  // Diagonal scan: stop on goal, forced neighbour, or a hit from either
  // component scan (vertical first).
  function automatic bit scan_diag(int x, int y, int dx, int dy, int gx, int gy,
                                   output int ox, output int oy);
    int tx, ty;
    bit got;
    got = 1'b0;
    ox = 0;
    oy = 0;
    for (int unsigned s = 1; s <= walk_limit; s++) begin
      x += dx;
      y += dy;
      if (!open_cell(x, y)) return 1'b0;
      got = 1'b1;
      ox = x;
      oy = y;
      if (x == gx && y == gy) break;
      if (!open_cell(x, y - dy) && open_cell(x + dx, y - dy)) break;
      if (!open_cell(x - dx, y) && open_cell(x - dx, y + dy)) break;
      if (scan_line(x, y, 0, dy, gx, gy, tx, ty)) break;
      if (scan_line(x, y, dx, 0, gx, gy, tx, ty)) break;
    end
    return got;
  endfunction

  // Apply one accepted word to the predictor and return its result.
  function automatic jump_t predict_jump(cmd_t c);
    jump_t r;
    int dx, dy, ox, oy;
    bit hit;
    r = '{1'b0, 8'd0, 8'd0};
    if (c.op == OP_WRITE) begin
      occ_map[int'(c.cy) * 256 + int'(c.cx)] = c.pass;
      return r;
    end
    dx = dir_dx(c.dir);
    dy = dir_dy(c.dir);
    if (c.dir < DIR_NE) hit = scan_line(c.cx, c.cy, dx, dy, c.gx, c.gy, ox, oy);
    else hit = scan_diag(c.cx, c.cy, dx, dy, c.gx, c.gy, ox, oy);
    if (hit) r = '{1'b1, 8'(ox), 8'(oy)};
    return r;
  endfunction

  // Driver: present the next word, hold it until taken, then idle a random gap.
  int unsigned gap_left = 0;
  cmd_t        cur_cmd;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) jump_expect = {jump_expect, predict_jump(cur_cmd)};
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (cmd_pending.size() > 0) begin
          cur_cmd = cmd_pending.pop_front();
          operation <= cur_cmd.op;
          cell_x <= cur_cmd.cx;
          cell_y <= cur_cmd.cy;
          passable <= cur_cmd.pass;
          direction <= cur_cmd.dir;
          goal_x <= cur_cmd.gx;
          goal_y <= cur_cmd.gy;
          start <= 1'b1;
          // Bias towards no gap so back-to-back words occur too.
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done cycle carries one result word.
  always @(posedge clk) begin
    jump_t e;
    if (!rst && done) begin
      if (jump_expect.size() == 0) begin
        $error("result word with nothing expected");
        failed = 1'b1;
      end else begin
        e = jump_expect.pop_front();
        if (found !== e.hit) begin
          $error("found: expected %0d, got %0d", e.hit, found);
          failed = 1'b1;
        end
        if (jump_x !== e.jx) begin
          $error("jump_x: expected %0d, got %0d", e.jx, jump_x);
          failed = 1'b1;
        end
        if (jump_y !== e.jy) begin
          $error("jump_y: expected %0d, got %0d", e.jy, jump_y);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic add_cmd(bit op, int cx, int cy, bit pass, int dir, int gx, int gy);
    cmd_t c;
    c = '{op, 8'(cx), 8'(cy), pass, 3'(dir), 8'(gx), 8'(gy)};
    cmd_pending = {cmd_pending, c};
  endtask

  task automatic wait_idle();
    while (cmd_pending.size() > 0 || start || jump_expect.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Raise valid, wait for the edge that takes the word, then drop valid.
  task automatic write_limit(int unsigned v);
    @(posedge clk);
    cfg_data <= v[StepW-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    walk_limit = cfg_data;
    cfg_valid <= 1'b0;
  endtask

  // Random writes and query starts confined to a 16x16 window, so walks
  // mostly end quickly against blocked cells around it.
  task automatic random_phase(int n);
    int wx, wy, x, y;
    wx = $urandom_range(0, 240);
    wy = $urandom_range(0, 240);
    if ($urandom_range(0, 3) == 0) wx = ($urandom_range(0, 1) != 0) ? 240 : 0;
    if ($urandom_range(0, 3) == 0) wy = ($urandom_range(0, 1) != 0) ? 240 : 0;
    for (int i = 0; i < n; i++) begin
      x = wx + $urandom_range(0, 15);
      y = wy + $urandom_range(0, 15);
      if ($urandom_range(0, 1) == 0 || i < 40) begin
        add_cmd(OP_WRITE, x, y, $urandom_range(0, 9) < 7, $urandom_range(0, 7),
                $urandom_range(0, 255), $urandom_range(0, 255));
      end else if ($urandom_range(0, 1) == 0) begin
        add_cmd(OP_QUERY, x, y, $urandom_range(0, 1), $urandom_range(0, 7),
                wx + $urandom_range(0, 15), wy + $urandom_range(0, 15));
      end else begin
        add_cmd(OP_QUERY, x, y, $urandom_range(0, 1), $urandom_range(0, 7),
                $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // Directed: corners, edges of the grid, goal hit, forced neighbour.
    add_cmd(OP_WRITE, 0, 0, 1, 0, 0, 0);
    add_cmd(OP_WRITE, 1, 1, 1, 0, 0, 0);
    add_cmd(OP_WRITE, 2, 2, 1, 0, 0, 0);
    add_cmd(OP_WRITE, 255, 255, 1, 7, 255, 255);
    add_cmd(OP_WRITE, 254, 255, 1, 0, 0, 0);
    add_cmd(OP_WRITE, 2, 2, 0, 0, 0, 0);
    for (int d = 0; d < 8; d++) add_cmd(OP_QUERY, 1, 1, 0, d, 255, 255);
    add_cmd(OP_QUERY, 0, 0, 0, 5, 1, 1);
    add_cmd(OP_QUERY, 255, 255, 1, 2, 0, 0);
    add_cmd(OP_QUERY, 255, 255, 1, 3, 0, 0);
    add_cmd(OP_WRITE, 5, 5, 1, 0, 0, 0);
    add_cmd(OP_WRITE, 6, 5, 1, 0, 0, 0);
    add_cmd(OP_WRITE, 7, 5, 1, 0, 0, 0);
    add_cmd(OP_WRITE, 7, 4, 1, 0, 0, 0);
    add_cmd(OP_QUERY, 4, 5, 0, 2, 200, 200);
    wait_idle();
    random_phase(400);
    wait_idle();
    // Sweep the step limit: one, zero, above 256, random, reset value.
    write_limit(1);
    random_phase(250);
    wait_idle();
    write_limit(0);
    random_phase(150);
    wait_idle();
    write_limit(511);
    random_phase(300);
    wait_idle();
    write_limit($urandom_range(2, 12));
    random_phase(300);
    wait_idle();
    write_limit(256);
    random_phase(280);
    wait_idle();
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Clearing pass plus worst-case nested scans, with a wide margin.
  initial begin
    #400ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
